// ----- rtl/core/cps_pkg.sv -----
package cps_pkg;

	localparam logic [3:0] FN_LEFT       = 4'd0;
	localparam logic [3:0] FN_RIGHT      = 4'd1;
	localparam logic [3:0] FN_FWD        = 4'd2;
	localparam logic [3:0] FN_BACK       = 4'd3;
	localparam logic [3:0] FN_UP         = 4'd4;
	localparam logic [3:0] FN_DOWN       = 4'd5;
	localparam logic [3:0] FN_ROLL_PLUS  = 4'd8;
	localparam logic [3:0] FN_ROLL_MINUS = 4'd9;
	localparam logic [3:0] FN_FWD_STEP   = 4'd10;
	localparam logic [3:0] FN_RIGHT_STEP = 4'd11;
	localparam logic [3:0] FN_TURN       = 4'd12;
	localparam logic [3:0] FN_TURN_FOCUS = 4'd13;

	localparam logic [0:0] REG_FIXED_STEP = 1'b0;
	localparam logic [0:0] REG_ROLL_STEP  = 1'b1;

	localparam logic [30:0] FIXED_STEP_RST = 31'd13107;
	localparam logic [30:0] ROLL_STEP_RST  = 31'd327680;
	localparam logic signed [31:0] EYE_Y_RST = 32'sd6553600;
	localparam logic signed [31:0] EYE_Z_RST = 32'sd6553600;

	typedef logic signed [32:0] diff_t;
	typedef logic signed [33:0] move_t;

	typedef struct packed {
		logic [30:0] fixed_step;
		logic [30:0] roll_step;
	} cps_cfg_t;

	typedef struct packed {
		logic               start;
		diff_t              v0;
		diff_t              v1;
		diff_t              v2;
		logic signed [31:0] scale;
	} cps_norm_req_t;

	typedef struct packed {
		logic  done;
		move_t mv0;
		move_t mv1;
		move_t mv2;
	} cps_norm_rsp_t;

	function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
		if (v > 35'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -35'sd2147483648) begin
			return 32'sh80000000;
		end else begin
			return v[31:0];
		end
	endfunction

endpackage

// ----- rtl/core/cps_if.sv -----
interface cps_cmd_if;
	logic               valid;
	logic               ready;
	logic [3:0]         func;
	logic signed [31:0] step;
	logic               hang;
	logic signed [31:0] focus_x;
	logic signed [31:0] focus_y;
	logic signed [31:0] focus_z;
	modport source(output valid, func, step, hang, focus_x, focus_y, focus_z, input ready);
	modport sink(input valid, func, step, hang, focus_x, focus_y, focus_z, output ready);
endinterface

interface cps_pose_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] eye_x;
	logic signed [31:0] eye_y;
	logic signed [31:0] eye_z;
	logic signed [31:0] look_x;
	logic signed [31:0] look_y;
	logic signed [31:0] look_z;
	logic signed [31:0] roll_angle;
	modport source(output valid, eye_x, eye_y, eye_z, look_x, look_y, look_z, roll_angle,
		input ready);
	modport sink(input valid, eye_x, eye_y, eye_z, look_x, look_y, look_z, roll_angle,
		output ready);
endinterface

// ----- rtl/core/cps_regs.sv -----
module cps_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cps_pkg::cps_cfg_t cfg
);
	import cps_pkg::*;

	logic [30:0] fixed_step_q;
	logic [30:0] roll_step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixed_step_q <= FIXED_STEP_RST;
			roll_step_q  <= ROLL_STEP_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_FIXED_STEP: fixed_step_q <= pwdata[30:0];
				REG_ROLL_STEP:  roll_step_q  <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_FIXED_STEP: prdata = {1'b0, fixed_step_q};
			REG_ROLL_STEP:  prdata = {1'b0, roll_step_q};
			default:        prdata = '0;
		endcase
	end

	assign pready          = 1'b1;
	assign cfg.fixed_step  = fixed_step_q;
	assign cfg.roll_step   = roll_step_q;
endmodule

// ----- rtl/core/cps_norm.sv -----
module cps_norm (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cps_pkg::cps_norm_req_t req,
	output cps_pkg::cps_norm_rsp_t rsp
);
	import cps_pkg::*;

	typedef enum logic [7:0] {
		NS_IDLE  = 8'b00000001,
		NS_SHIFT = 8'b00000010,
		NS_SQ    = 8'b00000100,
		NS_ACC   = 8'b00001000,
		NS_SQRT  = 8'b00010000,
		NS_DINIT = 8'b00100000,
		NS_DIV   = 8'b01000000,
		NS_MUL   = 8'b10000000
	} norm_state_t;

	norm_state_t state_q;
	logic [2:0][32:0] mag_q;
	logic [2:0] neg_q;
	logic signed [31:0] scale_q;
	logic [61:0] acc_q;
	logic [61:0] res_q;
	logic [61:0] bit_q;
	logic [30:0] len_q;
	logic [1:0] idx_q;
	logic [4:0] cnt_q;
	logic [46:0] num_q;
	logic [30:0] rem_q;
	logic [16:0] quo_q;
	logic signed [63:0] prod_q;
	logic rnd_q;
	move_t [2:0] mv_q;
	logic done_q;

	logic all_small, any_big, all_zero;
	logic signed [31:0] mul_a, mul_b;
	logic [61:0] sq_t;
	logic [31:0] div_t;
	logic [63:0] prod_mag;
	logic [47:0] rnd_mag;
	logic [46:0] num_init;

	assign all_small = (mag_q[0][32:29] == '0) && (mag_q[1][32:29] == '0)
		&& (mag_q[2][32:29] == '0);
	assign any_big   = (mag_q[0][32:30] != '0) || (mag_q[1][32:30] != '0)
		|| (mag_q[2][32:30] != '0);
	assign all_zero  = (mag_q[0] == '0) && (mag_q[1] == '0) && (mag_q[2] == '0);
	assign sq_t      = res_q + bit_q;
	assign div_t     = {rem_q, num_q[16]};
	assign num_init  = {1'b0, mag_q[idx_q][29:0], 16'd0} + {17'd0, len_q[30:1]};
	assign prod_mag  = prod_q[63] ? 64'(-prod_q) : 64'(prod_q);
	assign rnd_mag   = 48'((prod_mag + 64'd32768) >> 16);

	// one multiplier serves both the squares and the step scaling
	always_comb begin
		if (state_q == NS_SQ) begin
			mul_a = {2'b0, mag_q[idx_q][29:0]};
			mul_b = {2'b0, mag_q[idx_q][29:0]};
		end else begin
			mul_a = neg_q[idx_q] ? -{15'd0, quo_q} : {15'd0, quo_q};
			mul_b = scale_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= NS_IDLE;
			done_q  <= 1'b0;
			rnd_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				NS_IDLE: begin
					if (req.start) begin
						mag_q[0] <= req.v0[32] ? 33'(-req.v0) : 33'(req.v0);
						mag_q[1] <= req.v1[32] ? 33'(-req.v1) : 33'(req.v1);
						mag_q[2] <= req.v2[32] ? 33'(-req.v2) : 33'(req.v2);
						neg_q    <= {req.v2[32], req.v1[32], req.v0[32]};
						scale_q  <= req.scale;
						mv_q     <= '0;
						state_q  <= NS_SHIFT;
					end
				end
				NS_SHIFT: begin
					if (all_zero) begin
						done_q  <= 1'b1;
						state_q <= NS_IDLE;
					end else if (all_small) begin
						mag_q[0] <= {mag_q[0][31:0], 1'b0};
						mag_q[1] <= {mag_q[1][31:0], 1'b0};
						mag_q[2] <= {mag_q[2][31:0], 1'b0};
					end else if (any_big) begin
						mag_q[0] <= mag_q[0] >> 1;
						mag_q[1] <= mag_q[1] >> 1;
						mag_q[2] <= mag_q[2] >> 1;
					end else begin
						acc_q   <= '0;
						idx_q   <= '0;
						state_q <= NS_SQ;
					end
				end
				NS_SQ: begin
					prod_q  <= mul_a * mul_b;
					state_q <= NS_ACC;
				end
				NS_ACC: begin
					acc_q <= acc_q + prod_q[61:0];
					if (idx_q == 2'd2) begin
						res_q   <= '0;
						bit_q   <= 62'd1 << 60;
						state_q <= NS_SQRT;
					end else begin
						idx_q   <= idx_q + 2'd1;
						state_q <= NS_SQ;
					end
				end
				NS_SQRT: begin
					if (acc_q >= sq_t) begin
						acc_q <= acc_q - sq_t;
						res_q <= (res_q >> 1) + bit_q;
						if (bit_q[0]) len_q <= res_q[31:1] + bit_q[30:0];
					end else begin
						res_q <= res_q >> 1;
						if (bit_q[0]) len_q <= res_q[31:1];
					end
					bit_q <= bit_q >> 2;
					if (bit_q[0]) begin
						idx_q   <= '0;
						state_q <= NS_DINIT;
					end
				end
				NS_DINIT: begin
					num_q   <= num_init;
					rem_q   <= {1'b0, num_init[46:17]};
					cnt_q   <= '0;
					state_q <= NS_DIV;
				end
				NS_DIV: begin
					if (div_t >= {1'b0, len_q}) begin
						rem_q <= 31'(div_t - {1'b0, len_q});
						quo_q <= {quo_q[15:0], 1'b1};
					end else begin
						rem_q <= div_t[30:0];
						quo_q <= {quo_q[15:0], 1'b0};
					end
					num_q <= {num_q[45:0], 1'b0};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd16) begin
						rnd_q   <= 1'b0;
						state_q <= NS_MUL;
					end
				end
				NS_MUL: begin
					// forms the product into prod_q first, then rounds it once rnd_q is set
					if (!rnd_q) begin
						prod_q <= mul_a * mul_b;
						rnd_q  <= 1'b1;
					end else begin
						mv_q[idx_q] <= prod_q[63] ? -$signed({1'b0, rnd_mag[32:0]})
							: $signed({1'b0, rnd_mag[32:0]});
						if (idx_q == 2'd2) begin
							done_q  <= 1'b1;
							state_q <= NS_IDLE;
						end else begin
							idx_q   <= idx_q + 2'd1;
							state_q <= NS_DINIT;
						end
					end
				end
				default: state_q <= NS_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.mv0  = mv_q[0];
	assign rsp.mv1  = mv_q[1];
	assign rsp.mv2  = mv_q[2];
endmodule

// ----- rtl/core/camera_pose_stepper.sv -----
// Camera pose stepper. Commands arrive on the cmd channel (valid/ready); each one
// moves the eye point, the look point or the roll (a no-op moves none), and gives
// one pose transaction on the pose channel carrying the full state after the move.
// The user must write registers fixed_step (address 0) and roll_step (address 4)
// over the APB port only while idle; the block itself does not enforce this.
// Roll, up/down and no-op commands skip the normaliser. Moves along a unit vector
// run through it: magnitude shifting, the sum of squares, a bit-serial integer
// square root and, per component, a bit-serial divide and the step scaling; then
// the pose is updated and presented. A zero vector leaves the normaliser straight
// after the first shift check, with a zero move.
// One command is in flight at a time; cmd.ready is high while the sequencer is idle,
// also while a finished pose still waits in the output register.
// If the receiver stalls, the next command runs to completion and then holds until
// the output register is free.
// Reset sets eye (0, 100, 100), look (0, 0, 0), roll 0, fixed_step 0.2, roll_step 5.
module camera_pose_stepper (
	input  logic        clk,
	input  logic        arst_n,
	cps_cmd_if.sink     cmd,
	cps_pose_if.source  pose,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import cps_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_NORM = 4'b0010,
		ST_UPD  = 4'b0100,
		ST_OUT  = 4'b1000
	} seq_state_t;

	seq_state_t state_q;
	cps_cfg_t cfg;
	cps_norm_req_t nreq;
	cps_norm_rsp_t nrsp;

	logic signed [31:0] eye_q [3];
	logic signed [31:0] look_q [3];
	logic signed [31:0] roll_q;
	logic signed [31:0] focus_q [3];
	move_t mv_q [3];
	logic [3:0] func_q;
	logic neg_q, move_eye_q, move_look_q, set_focus_q;
	logic out_valid_q;
	logic signed [31:0] out_q [7];

	diff_t d0, d1, d2;
	logic is_side, is_dir, is_turnf, is_vert;
	logic pose_load;

	cps_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	cps_norm u_norm (.clk(clk), .arst_n(arst_n), .req(nreq), .rsp(nrsp));

	assign d0 = 33'(look_q[0]) - 33'(eye_q[0]);
	assign d1 = 33'(look_q[1]) - 33'(eye_q[1]);
	assign d2 = 33'(look_q[2]) - 33'(eye_q[2]);

	assign is_side  = (cmd.func == FN_LEFT) || (cmd.func == FN_RIGHT)
		|| (cmd.func == FN_RIGHT_STEP) || (cmd.func == FN_TURN);
	assign is_dir   = (cmd.func == FN_FWD) || (cmd.func == FN_BACK)
		|| (cmd.func == FN_FWD_STEP);
	assign is_turnf = (cmd.func == FN_TURN_FOCUS);
	assign is_vert  = (cmd.func == FN_UP) || (cmd.func == FN_DOWN);

	// hand the finished pose to the output register once it is free
	assign pose_load = (state_q == ST_OUT) && (!out_valid_q || pose.ready);

	always_comb begin
		nreq.start = (state_q == ST_IDLE) && cmd.valid && (is_side || is_dir || is_turnf);
		nreq.scale = (cmd.func <= FN_BACK) ? {1'b0, cfg.fixed_step} : cmd.step;
		if (is_turnf) begin
			nreq.v0 = 33'(eye_q[1]) - 33'(cmd.focus_y);
			nreq.v1 = 33'(cmd.focus_x) - 33'(eye_q[0]);
			nreq.v2 = '0;
		end else if (is_dir) begin
			nreq.v0 = d0;
			nreq.v1 = d1;
			nreq.v2 = (cmd.func == FN_FWD_STEP && cmd.hang) ? '0 : d2;
		end else begin
			nreq.v0 = d1;
			nreq.v1 = -d0;
			nreq.v2 = '0;
		end
	end

	assign cmd.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			eye_q[0]    <= '0;
			eye_q[1]    <= EYE_Y_RST;
			eye_q[2]    <= EYE_Z_RST;
			look_q[0]   <= '0;
			look_q[1]   <= '0;
			look_q[2]   <= '0;
			roll_q      <= '0;
		end else begin
			if (pose_load) begin
				out_valid_q <= 1'b1;
			end else if (pose.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.valid) begin
						func_q      <= cmd.func;
						focus_q[0]  <= cmd.focus_x;
						focus_q[1]  <= cmd.focus_y;
						focus_q[2]  <= cmd.focus_z;
						neg_q       <= (cmd.func == FN_RIGHT) || (cmd.func == FN_BACK)
							|| (cmd.func == FN_DOWN);
						move_look_q <= is_side || is_dir || is_vert;
						move_eye_q  <= (is_side && cmd.func != FN_TURN) || is_dir || is_vert
							|| is_turnf;
						set_focus_q <= is_turnf;
						mv_q[0]     <= '0;
						mv_q[1]     <= '0;
						mv_q[2]     <= is_vert ? move_t'({1'b0, cfg.fixed_step}) : '0;
						state_q     <= nreq.start ? ST_NORM : ST_UPD;
					end
				end
				ST_NORM: begin
					if (nrsp.done) begin
						mv_q[0] <= nrsp.mv0;
						mv_q[1] <= nrsp.mv1;
						mv_q[2] <= nrsp.mv2;
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					for (int i = 0; i < 3; i++) begin
						if (move_eye_q) begin
							eye_q[i] <= sat32(35'(eye_q[i]) + (neg_q ? -35'(mv_q[i])
								: 35'(mv_q[i])));
						end
						if (set_focus_q) begin
							look_q[i] <= focus_q[i];
						end else if (move_look_q) begin
							look_q[i] <= sat32(35'(look_q[i]) + (neg_q ? -35'(mv_q[i])
								: 35'(mv_q[i])));
						end
					end
					if (func_q == FN_ROLL_PLUS) begin
						roll_q <= sat32(35'(roll_q) + 35'($signed({1'b0, cfg.roll_step})));
					end else if (func_q == FN_ROLL_MINUS) begin
						roll_q <= sat32(35'(roll_q) - 35'($signed({1'b0, cfg.roll_step})));
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					// hold until the output register is free
					if (pose_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pose_load) begin
			out_q[0] <= eye_q[0];
			out_q[1] <= eye_q[1];
			out_q[2] <= eye_q[2];
			out_q[3] <= look_q[0];
			out_q[4] <= look_q[1];
			out_q[5] <= look_q[2];
			out_q[6] <= roll_q;
		end
	end

	assign pose.valid      = out_valid_q;
	assign pose.eye_x      = out_q[0];
	assign pose.eye_y      = out_q[1];
	assign pose.eye_z      = out_q[2];
	assign pose.look_x     = out_q[3];
	assign pose.look_y     = out_q[4];
	assign pose.look_z     = out_q[5];
	assign pose.roll_angle = out_q[6];
endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
	import cps_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD      = 400;
	localparam int PHASE_ITEMS    = 385;

	typedef struct {
		logic [3:0]         func;
		logic signed [31:0] step;
		logic               hang;
		logic signed [31:0] focus_x;
		logic signed [31:0] focus_y;
		logic signed [31:0] focus_z;
	} camera_cmd_t;

	typedef struct {
		logic signed [31:0] f[7];
	} pose_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	cps_cmd_if  cmd ();
	cps_pose_if pose ();

	camera_pose_stepper DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.pose    (pose),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	camera_cmd_t pending_cmds[$];
	pose_t       expected_poses[$];

	// shadow camera state and registers
	longint eye[3];
	longint look[3];
	longint roll;
	longint fixed_step;
	longint roll_step;

	int  mismatches;
	int  idle_cycles;
	int  send_gap;
	int  recv_gap;
	int  hold_cnt;
	bit  stall_req;
	bit  calm;
	bit  cmd_taken;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint sat32(input longint v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end else if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// unit vector of v times s, Q16.16, rounded half away from zero
	function automatic void unit_move(input longint vx, input longint vy, input longint vz,
		input longint s, output longint mx, output longint my, output longint mz);
		longint          v[3];
		longint          res[3];
		longint unsigned m[3];
		longint unsigned top;
		longint unsigned sq;
		longint unsigned len;
		longint unsigned bitv;
		longint unsigned q;
		longint unsigned pm;
		longint          u;
		longint          p;
		v = '{vx, vy, vz};
		top = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = v[i] < 0 ? longint'(-v[i]) : longint'(v[i]);
			if (m[i] > top) top = m[i];
			res[i] = 0;
		end
		if (top != 0) begin
			while (top < (64'd1 << 29)) begin
				top = top << 1;
				for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
			end
			while (top >= (64'd1 << 30)) begin
				top = top >> 1;
				for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
			end
			sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
			len = 0;
			bitv = 64'd1 << 62;
			while (bitv > sq) bitv = bitv >> 2;
			while (bitv != 0) begin
				if (sq >= len + bitv) begin
					sq = sq - (len + bitv);
					len = (len >> 1) + bitv;
				end else begin
					len = len >> 1;
				end
				bitv = bitv >> 2;
			end
			if (len != 0) begin
				for (int i = 0; i < 3; i++) begin
					q = (m[i] * 64'd65536 + (len >> 1)) / len;
					u = v[i] < 0 ? -longint'(q) : longint'(q);
					p = u * s;
					pm = ((p < 0 ? longint'(-p) : longint'(p)) + 64'd32768) >> 16;
					res[i] = p < 0 ? -longint'(pm) : longint'(pm);
				end
			end
		end
		mx = res[0];
		my = res[1];
		mz = res[2];
	endfunction

	function automatic pose_t advance_pose(input camera_cmd_t c);
		longint d[3];
		longint mv[3];
		longint stp;
		longint sgn;
		bit     move_eye;
		bit     move_look;
		pose_t  r;
		for (int i = 0; i < 3; i++) begin
			d[i] = look[i] - eye[i];
			mv[i] = 0;
		end
		stp = longint'(c.step);
		sgn = 1;
		move_eye = 1'b1;
		move_look = 1'b1;
		case (c.func)
			FN_LEFT, FN_RIGHT: begin
				unit_move(d[1], -d[0], 0, fixed_step, mv[0], mv[1], mv[2]);
				if (c.func == FN_RIGHT) sgn = -1;
			end
			FN_FWD, FN_BACK: begin
				unit_move(d[0], d[1], d[2], fixed_step, mv[0], mv[1], mv[2]);
				if (c.func == FN_BACK) sgn = -1;
			end
			FN_UP, FN_DOWN: begin
				mv[2] = fixed_step;
				if (c.func == FN_DOWN) sgn = -1;
			end
			FN_ROLL_PLUS: roll = sat32(roll + roll_step);
			FN_ROLL_MINUS: roll = sat32(roll - roll_step);
			FN_FWD_STEP: begin
				unit_move(d[0], d[1], c.hang ? 0 : d[2], stp, mv[0], mv[1], mv[2]);
			end
			FN_RIGHT_STEP: unit_move(d[1], -d[0], 0, stp, mv[0], mv[1], mv[2]);
			FN_TURN: begin
				unit_move(d[1], -d[0], 0, stp, mv[0], mv[1], mv[2]);
				move_eye = 1'b0;
			end
			FN_TURN_FOCUS: begin
				unit_move(eye[1] - longint'(c.focus_y), longint'(c.focus_x) - eye[0], 0,
					stp, mv[0], mv[1], mv[2]);
				look[0] = longint'(c.focus_x);
				look[1] = longint'(c.focus_y);
				look[2] = longint'(c.focus_z);
				move_look = 1'b0;
			end
			default: ;
		endcase
		for (int i = 0; i < 3; i++) begin
			if (move_look) look[i] = sat32(look[i] + sgn * mv[i]);
			if (move_eye) eye[i] = sat32(eye[i] + sgn * mv[i]);
		end
		for (int i = 0; i < 3; i++) begin
			r.f[i] = eye[i][31:0];
			r.f[3 + i] = look[i][31:0];
		end
		r.f[6] = roll[31:0];
		return r;
	endfunction

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'sh7fffffff - $urandom_range(0, 3);
			2: return 32'sh80000000 + $urandom_range(0, 3);
			default: return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
		endcase
	endfunction

	function automatic camera_cmd_t rand_cmd();
		camera_cmd_t c;
		c.func = 4'($urandom_range(0, 15));
		c.hang = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 7))
			0: c.step = $urandom;
			1: c.step = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			2: c.step = 0;
			default: c.step = $signed($urandom_range(0, 32'h001fffff)) - 32'sh00100000;
		endcase
		c.focus_x = rand_coord();
		c.focus_y = rand_coord();
		c.focus_z = rand_coord();
		return c;
	endfunction

	function automatic camera_cmd_t make_cmd(input logic [3:0] func,
		input logic signed [31:0] step, input logic hang, input logic signed [31:0] fx,
		input logic signed [31:0] fy, input logic signed [31:0] fz);
		camera_cmd_t c;
		c.func = func;
		c.step = step;
		c.hang = hang;
		c.focus_x = fx;
		c.focus_y = fy;
		c.focus_z = fz;
		return c;
	endfunction

	task automatic note_mismatch(input string what, input logic [31:0] exp_v,
		input logic [31:0] got_v);
		mismatches++;
		if (mismatches <= 10) begin
			$display("mismatch %s: expected %h, got %h", what, exp_v, got_v);
		end
	endtask

	task automatic wait_drained();
		while (pending_cmds.size() != 0 || expected_poses.size() != 0 || cmd.valid) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(input logic [0:0] idx, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_FIXED_STEP) begin
			fixed_step = longint'({33'd0, data[30:0]});
		end else begin
			roll_step = longint'({33'd0, data[30:0]});
		end
	endtask

	task automatic push_random(input int n);
		repeat (n) pending_cmds.push_back(rand_cmd());
	endtask

	// sender
	always @(negedge clk) begin
		camera_cmd_t c;
		if (arst_n && (!cmd.valid || cmd_taken)) begin
			if (send_gap > 0) begin
				send_gap--;
				cmd.valid <= 1'b0;
			end else if (pending_cmds.size() != 0) begin
				c = pending_cmds.pop_front();
				cmd.valid <= 1'b1;
				cmd.func <= c.func;
				cmd.step <= c.step;
				cmd.hang <= c.hang;
				cmd.focus_x <= c.focus_x;
				cmd.focus_y <= c.focus_y;
				cmd.focus_z <= c.focus_z;
				if (!calm && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 19);
			end else begin
				cmd.valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_req) begin
				stall_req = 1'b0;
				hold_cnt = LONG_HOLD;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				pose.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				pose.ready <= 1'b0;
			end else begin
				pose.ready <= 1'b1;
				if (!calm && $urandom_range(0, 9) == 0) recv_gap = $urandom_range(1, 19);
			end
		end
	end

	// predict on command transactions, check pose transactions
	always @(posedge clk) begin
		camera_cmd_t c;
		pose_t       exp_p;
		logic signed [31:0] got[7];
		string       names[7];
		cmd_taken <= cmd.valid && cmd.ready;
		if (arst_n) begin
			names = '{"eye_x", "eye_y", "eye_z", "look_x", "look_y", "look_z", "roll_angle"};
			if (cmd.valid && cmd.ready) begin
				c = make_cmd(cmd.func, cmd.step, cmd.hang, cmd.focus_x, cmd.focus_y,
					cmd.focus_z);
				expected_poses.push_back(advance_pose(c));
			end
			if (pose.valid && pose.ready) begin
				got = '{pose.eye_x, pose.eye_y, pose.eye_z, pose.look_x, pose.look_y,
					pose.look_z, pose.roll_angle};
				if (expected_poses.size() == 0) begin
					note_mismatch("unexpected pose", 32'h0, got[0]);
				end else begin
					exp_p = expected_poses.pop_front();
					for (int i = 0; i < 7; i++) begin
						if (got[i] !== exp_p.f[i]) note_mismatch(names[i], exp_p.f[i], got[i]);
					end
				end
			end
			if ((cmd.valid && cmd.ready) || (pose.valid && pose.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("CHECKS FAILED");
					$finish;
				end
			end
		end
	end

	initial begin
		logic signed [31:0] ex;
		logic signed [31:0] ey;
		logic signed [31:0] ez;
		arst_n = 1'b0;
		cmd.valid = 1'b0;
		cmd.func = '0;
		cmd.step = '0;
		cmd.hang = 1'b0;
		cmd.focus_x = '0;
		cmd.focus_y = '0;
		cmd.focus_z = '0;
		pose.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		eye = '{0, 64'sd6553600, 64'sd6553600};
		look = '{0, 0, 0};
		roll = 0;
		fixed_step = longint'({33'd0, FIXED_STEP_RST});
		roll_step = longint'({33'd0, ROLL_STEP_RST});
		mismatches = 0;
		idle_cycles = 0;
		send_gap = 0;
		recv_gap = 0;
		hold_cnt = 0;
		stall_req = 1'b0;
		calm = 1'b0;
		cmd_taken = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// every command at reset registers, then the extremes of step and focus
		for (int f = 0; f < 16; f++) begin
			pending_cmds.push_back(make_cmd(4'(f), 32'sh00020000, f[0], 32'sh00010000,
				-32'sh00030000, 32'sh00005000));
		end
		pending_cmds.push_back(make_cmd(FN_FWD_STEP, 32'sh7fffffff, 1'b1, 0, 0, 0));
		pending_cmds.push_back(make_cmd(FN_FWD_STEP, 32'sh80000000, 1'b0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(FN_TURN_FOCUS, 32'sh80000000, 1'b0,
			32'sh7fffffff, 32'sh80000000, 32'sh7fffffff));
		pending_cmds.push_back(make_cmd(FN_TURN, 32'sh7fffffff, 1'b1,
			32'sh80000000, 32'sh7fffffff, 32'sh80000000));
		wait_drained();

		// eye on the focus point: every direction collapses to zero
		ex = eye[0][31:0];
		ey = eye[1][31:0];
		ez = eye[2][31:0];
		pending_cmds.push_back(make_cmd(FN_TURN_FOCUS, 32'sh00050000, 1'b0, ex, ey, ez));
		pending_cmds.push_back(make_cmd(FN_FWD, 0, 1'b0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(FN_LEFT, 0, 1'b0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(FN_FWD_STEP, 32'sh00040000, 1'b1, 0, 0, 0));
		pending_cmds.push_back(make_cmd(FN_TURN, 32'sh00040000, 1'b0, 0, 0, 0));
		push_random(PHASE_ITEMS);
		wait_drained();

		apb_write(REG_FIXED_STEP, 32'h8000_0000);
		apb_write(REG_ROLL_STEP, 32'h0000_0000);
		push_random(PHASE_ITEMS);
		stall_req = 1'b1;
		wait_drained();

		apb_write(REG_FIXED_STEP, 32'h7fff_ffff);
		apb_write(REG_ROLL_STEP, 32'hffff_ffff);
		push_random(PHASE_ITEMS);
		wait_drained();

		apb_write(REG_FIXED_STEP, $urandom);
		apb_write(REG_ROLL_STEP, $urandom);
		push_random(PHASE_ITEMS);
		wait_drained();

		// last stretch at full rate on both sides
		apb_write(REG_FIXED_STEP, {1'b0, FIXED_STEP_RST});
		apb_write(REG_ROLL_STEP, {1'b0, ROLL_STEP_RST});
		calm = 1'b1;
		send_gap = 0;
		recv_gap = 0;
		push_random(PHASE_ITEMS);
		wait_drained();
		repeat (150) @(posedge clk);

		if (mismatches == 0 && expected_poses.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
